// File: rtl/dqir_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dqir_pkg: shared types and constants of the deque
// Field widths, action and status codes, controller states and the command
// bundle from controller to datapath.
// ----------------------------------------------------------------------------
package dqir_pkg;

    localparam int ACTION_W   = 3;
    localparam int VALUE_W    = 32;
    localparam int INDEX_W    = 4;
    localparam int DATA_OUT_W = 32;
    localparam int STATUS_W   = 3;
    localparam int COUNT_W    = 5;

    localparam int S_TDATA_W  = 40;  // value + index, padded to bytes
    localparam int S_TUSER_W  = 3;   // action
    localparam int M_TDATA_W  = 40;  // data + element_count, padded to bytes
    localparam int M_TUSER_W  = 4;   // data_valid + status

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_BACK  = 3'd1,
        ACT_POP_FRONT  = 3'd2,
        ACT_POP_BACK   = 3'd3,
        ACT_READ_INDEX = 3'd4,
        ACT_ITER_RESET = 3'd5,
        ACT_ITER_NEXT  = 3'd6
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 3'd0,
        STAT_FULL  = 3'd1,
        STAT_EMPTY = 3'd2,
        STAT_RANGE = 3'd3,
        STAT_END   = 3'd4
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } ctrl_state_t;

    typedef struct packed {
        logic load;   // capture the incoming transaction
        logic exec;   // carry out the captured action and load the result
    } cmd_t;

endpackage
`default_nettype wire

// File: rtl/dqir_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dqir_ctrl: deque controller
// Sequences capture and execution of one action and owns the result valid.
// ----------------------------------------------------------------------------
module dqir_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output dqir_pkg::cmd_t      cmd
);

    dqir_pkg::ctrl_state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic slot_free;

    assign slot_free = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= dqir_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            dqir_pkg::S_IDLE: begin
                if (s_tvalid) state_next = dqir_pkg::S_EXEC;
            end
            dqir_pkg::S_EXEC: begin
                if (slot_free) state_next = dqir_pkg::S_IDLE;
            end
            default: state_next = dqir_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_tready = 1'b0;
        cmd      = '0;
        unique case (state_reg)
            dqir_pkg::S_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            dqir_pkg::S_EXEC: begin
                // hold until the result register is free or being emptied
                cmd.exec = slot_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.exec) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule
`default_nettype wire

// File: rtl/dqir_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dqir_dp: deque datapath
// Ring-buffer memory, head/occupancy/iterator registers, slot arithmetic and
// the result register.
// ----------------------------------------------------------------------------
module dqir_dp #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire dqir_pkg::cmd_t                     cmd,
    input  wire logic [dqir_pkg::S_TDATA_W-1:0]     s_tdata,
    input  wire logic [dqir_pkg::S_TUSER_W-1:0]     s_tuser,
    output logic      [dqir_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic      [dqir_pkg::M_TUSER_W-1:0]     m_tuser
);

    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW      = $clog2(DEPTH + 1);
    localparam int IdxW    = dqir_pkg::INDEX_W;
    localparam int CmpW    = (CW > IdxW) ? CW : IdxW;
    localparam int CntW    = dqir_pkg::COUNT_W;
    localparam int OutW    = dqir_pkg::DATA_OUT_W;
    localparam int ValW    = dqir_pkg::VALUE_W;
    localparam int StatW   = dqir_pkg::STATUS_W;
    localparam int PadW    = dqir_pkg::M_TDATA_W - OutW - CntW;

    localparam logic [CW-1:0] FullCnt  = CW'(DEPTH);
    localparam logic [CW-1:0] OneCnt   = CW'(1);
    localparam logic [AW-1:0] LastSlot = AW'(DEPTH - 1);
    localparam logic [AW:0]   DepthSum = (AW + 1)'(DEPTH);

    // captured transaction
    dqir_pkg::action_t       action_reg;
    logic [DATA_WIDTH-1:0]   value_reg;
    logic [IdxW-1:0]         index_reg;

    // deque state
    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] occ_reg,  occ_next;
    logic [CW-1:0] iter_reg, iter_next;

    // result register
    logic [DATA_WIDTH-1:0]   rd_reg;
    logic                    valid_reg, valid_next;
    dqir_pkg::status_t       status_reg, status_next;
    logic [CntW-1:0]         count_reg;

    logic [DATA_WIDTH-1:0]   mem [DEPTH];

    logic          wr_en, rd_en, use_head;
    logic [AW-1:0] offset;
    logic [AW:0]   slot_sum;
    logic [AW-1:0] slot;
    logic [AW-1:0] mem_addr;
    logic          full, empty;
    logic [OutW-1:0] data_out;

    assign full  = (occ_reg == FullCnt);
    assign empty = (occ_reg == '0);

    // slot of element k from the front: (head + k) mod DEPTH, with k < DEPTH
    assign slot_sum = {1'b0, head_reg} + {1'b0, offset};
    assign slot     = (slot_sum >= DepthSum) ? AW'(slot_sum - DepthSum)
                                             : slot_sum[AW-1:0];
    assign mem_addr = use_head ? head_next : slot;

    always_comb begin
        head_next   = head_reg;
        occ_next    = occ_reg;
        iter_next   = iter_reg;
        valid_next  = 1'b0;
        status_next = dqir_pkg::STAT_OK;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        use_head    = 1'b0;
        offset      = '0;
        unique case (action_reg)
            dqir_pkg::ACT_PUSH_FRONT: begin
                use_head = 1'b1;
                if (full) begin
                    status_next = dqir_pkg::STAT_FULL;
                end else begin
                    head_next = (head_reg == '0) ? LastSlot : head_reg - AW'(1);
                    wr_en     = 1'b1;
                    occ_next  = occ_reg + OneCnt;
                    if (iter_reg != '0) iter_next = iter_reg + OneCnt;
                end
            end
            dqir_pkg::ACT_PUSH_BACK: begin
                offset = AW'(occ_reg);
                if (full) begin
                    status_next = dqir_pkg::STAT_FULL;
                end else begin
                    wr_en    = 1'b1;
                    occ_next = occ_reg + OneCnt;
                end
            end
            dqir_pkg::ACT_POP_FRONT: begin
                priority if (empty) begin
                    status_next = dqir_pkg::STAT_EMPTY;
                end else if (occ_reg == OneCnt) begin
                    occ_next  = '0;
                    head_next = '0;
                    iter_next = '0;
                end else begin
                    head_next = (head_reg == LastSlot) ? '0 : head_reg + AW'(1);
                    occ_next  = occ_reg - OneCnt;
                    if (iter_reg != '0) iter_next = iter_reg - OneCnt;
                end
            end
            dqir_pkg::ACT_POP_BACK: begin
                priority if (empty) begin
                    status_next = dqir_pkg::STAT_EMPTY;
                end else if (occ_reg == OneCnt) begin
                    occ_next  = '0;
                    head_next = '0;
                    iter_next = '0;
                end else begin
                    // drop the iterator when its last returned element leaves
                    if (iter_reg == occ_reg) iter_next = '0;
                    occ_next = occ_reg - OneCnt;
                end
            end
            dqir_pkg::ACT_READ_INDEX: begin
                offset = AW'(index_reg);
                priority if (empty) begin
                    status_next = dqir_pkg::STAT_EMPTY;
                end else if (CmpW'(index_reg) >= CmpW'(occ_reg)) begin
                    status_next = dqir_pkg::STAT_RANGE;
                end else begin
                    rd_en      = 1'b1;
                    valid_next = 1'b1;
                end
            end
            dqir_pkg::ACT_ITER_RESET: begin
                iter_next = '0;
            end
            dqir_pkg::ACT_ITER_NEXT: begin
                offset = AW'(iter_reg);
                if (iter_reg >= occ_reg) begin
                    status_next = dqir_pkg::STAT_END;
                end else begin
                    rd_en      = 1'b1;
                    valid_next = 1'b1;
                    iter_next  = iter_reg + OneCnt;
                end
            end
            default: begin
                status_next = dqir_pkg::STAT_OK;
            end
        endcase
    end

    // capture the accepted transaction
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            action_reg <= dqir_pkg::action_t'(s_tuser[dqir_pkg::ACTION_W-1:0]);
            value_reg  <= DATA_WIDTH'(s_tdata[ValW-1:0]);
            index_reg  <= s_tdata[ValW +: IdxW];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            occ_reg  <= '0;
            iter_reg <= '0;
        end else if (cmd.exec) begin
            head_reg <= head_next;
            occ_reg  <= occ_next;
            iter_reg <= iter_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            valid_reg  <= valid_next;
            status_reg <= status_next;
            count_reg  <= CntW'(occ_next);
        end
    end

    // single-port ring buffer, registered read
    always_ff @(posedge aclk) begin
        if (cmd.exec && wr_en) begin
            mem[mem_addr] <= value_reg;
        end
        if (cmd.exec && rd_en) begin
            rd_reg <= mem[mem_addr];
        end
    end

    assign data_out = valid_reg ? OutW'(rd_reg) : '0;
    assign m_tdata  = {{PadW{1'b0}}, count_reg, data_out};
    assign m_tuser  = {StatW'(status_reg), valid_reg};

endmodule
`default_nettype wire

// File: rtl/deque_with_indexed_read.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// deque_with_indexed_read: bounded double-ended queue with indexed read
// Ring-buffer deque with front/back push and pop, read by index and a
// forward iterator; one result transaction per input transaction.
// ----------------------------------------------------------------------------
// Each input transaction carries one action (push front, push back, pop
// front, pop back, read index, iterator reset, iterator next) and yields
// exactly one result with the data read, a data-valid flag, a status code and
// the element count after the action. Each action is first captured, then
// executed, which updates the pointers and performs the single access to the
// ring-buffer memory, whose read data is registered. A new transaction is
// taken while the previous result still waits on the output; execution holds
// only if that result has not been taken by then. Pushes on a full queue are
// dropped with status full, pops and reads on an empty queue report empty, an
// out-of-range index reports range, and the iterator stops at the end.
module deque_with_indexed_read #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // value[31:0], index[35:32], zero pad[39:36]
    input  wire logic [dqir_pkg::S_TDATA_W-1:0]   s_tdata,
    // action[2:0]
    input  wire logic [dqir_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // data[31:0], element_count[36:32], zero pad[39:37]
    output logic      [dqir_pkg::M_TDATA_W-1:0]   m_tdata,
    // data_valid[0], status[3:1]
    output logic      [dqir_pkg::M_TUSER_W-1:0]   m_tuser
);

    dqir_pkg::cmd_t cmd;

    dqir_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    dqir_dp #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

endmodule
`default_nettype wire
